@@ rtl/core/ntwt_pkg.sv @@
// Shared types, constants and the control-store program for the number-to-words block.
package ntwt_pkg;

    localparam int NUMBER_BITS = 31;
    localparam int BCD_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int CODE_W      = 5;
    localparam int PC_W        = 5;
    localparam int CNT_W       = $clog2(NUMBER_BITS + 1);

    localparam logic [CODE_W-1:0] CODE_ZERO      = 5'd0;
    localparam logic [CODE_W-1:0] CODE_TEN       = 5'd10;
    localparam logic [CODE_W-1:0] CODE_TENS_BASE = 5'd18;
    localparam logic [CODE_W-1:0] CODE_HUNDRED   = 5'd28;
    localparam logic [CODE_W-1:0] CODE_BILLION   = 5'd31;

    localparam logic [1:0] GRP_BILLIONS  = 2'd0;
    localparam logic [1:0] GRP_MILLIONS  = 2'd1;
    localparam logic [1:0] GRP_THOUSANDS = 2'd2;
    localparam logic [1:0] GRP_UNITS     = 2'd3;

    localparam logic [PC_W-1:0] PC_FLUSH = 5'd22;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_ZERO,
        OP_HUND,
        OP_HWORD,
        OP_TENS,
        OP_ONES,
        OP_SCALE,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [1:0]      grp;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic                                done;
        logic [BCD_DIGITS-1:0][DIGIT_W-1:0] digits;
    } bcd_status_t;

    function automatic uword_t uw(input op_t op, input logic [1:0] grp,
                                  input logic [PC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.grp    = grp;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step; each group walks the same five steps.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            5'd0:    w = uw(OP_WAIT,  GRP_BILLIONS,  '0);
            5'd1:    w = uw(OP_ZERO,  GRP_BILLIONS,  PC_FLUSH);
            5'd2:    w = uw(OP_HUND,  GRP_BILLIONS,  '0);
            5'd3:    w = uw(OP_HWORD, GRP_BILLIONS,  '0);
            5'd4:    w = uw(OP_TENS,  GRP_BILLIONS,  '0);
            5'd5:    w = uw(OP_ONES,  GRP_BILLIONS,  '0);
            5'd6:    w = uw(OP_SCALE, GRP_BILLIONS,  '0);
            5'd7:    w = uw(OP_HUND,  GRP_MILLIONS,  '0);
            5'd8:    w = uw(OP_HWORD, GRP_MILLIONS,  '0);
            5'd9:    w = uw(OP_TENS,  GRP_MILLIONS,  '0);
            5'd10:   w = uw(OP_ONES,  GRP_MILLIONS,  '0);
            5'd11:   w = uw(OP_SCALE, GRP_MILLIONS,  '0);
            5'd12:   w = uw(OP_HUND,  GRP_THOUSANDS, '0);
            5'd13:   w = uw(OP_HWORD, GRP_THOUSANDS, '0);
            5'd14:   w = uw(OP_TENS,  GRP_THOUSANDS, '0);
            5'd15:   w = uw(OP_ONES,  GRP_THOUSANDS, '0);
            5'd16:   w = uw(OP_SCALE, GRP_THOUSANDS, '0);
            5'd17:   w = uw(OP_HUND,  GRP_UNITS,     '0);
            5'd18:   w = uw(OP_HWORD, GRP_UNITS,     '0);
            5'd19:   w = uw(OP_TENS,  GRP_UNITS,     '0);
            5'd20:   w = uw(OP_ONES,  GRP_UNITS,     '0);
            5'd21:   w = uw(OP_SCALE, GRP_UNITS,     '0);
            default: w = uw(OP_FLUSH, GRP_UNITS,     '0);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/ntwt_bcd.sv @@
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
module ntwt_bcd
    import ntwt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUMBER_BITS-1:0] bin,
    output bcd_status_t            status
);

    logic                              run_reg, run_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [NUMBER_BITS-1:0]            bin_reg, bin_next;
    logic [BCD_DIGITS*DIGIT_W-1:0]     dig_reg, dig_next;
    logic [BCD_DIGITS*DIGIT_W-1:0]     adj;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (dig_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[i*DIGIT_W +: DIGIT_W] = dig_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[i*DIGIT_W +: DIGIT_W] = dig_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        bin_next = bin_reg;
        dig_next = dig_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            bin_next = bin;
            dig_next = '0;
        end
        else if (run_reg)
        begin
            dig_next = {adj[BCD_DIGITS*DIGIT_W-2:0], bin_reg[NUMBER_BITS-1]};
            bin_next = bin_reg << 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUMBER_BITS - 1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        dig_reg <= dig_next;
    end

    assign status.done   = !run_reg;
    assign status.digits = dig_reg;

endmodule

@@ rtl/core/number_to_word_tokens.sv @@
// Flow: a number is taken only while idle; the serial BCD conversion runs first, then the
// 23-step control program emits the words, and output stalls hold the program. The last
// word is marked with last_word when the program reaches its flush step.
// Reset: rst_n clears the sequencer, the word buffer and the output valid at once.
module number_to_word_tokens
    import ntwt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [NUMBER_BITS-1:0] number,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CODE_W-1:0]      word_code,
    output logic                   last_word
);

    bcd_status_t         bcd;
    uword_t              ctrl;
    logic                accept;
    logic                busy_reg, busy_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0]   pend_code_reg, pend_code_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;
    logic                out_last_reg, out_last_next;
    logic [DIGIT_W-1:0]  dh, dt, dd;
    logic                num_zero;
    logic                emit;
    logic [CODE_W-1:0]   code;
    logic                push_pend;
    logic                out_free;
    logic                advance;

    assign accept   = in_valid && in_ready;
    assign in_ready = !busy_reg;

    ntwt_bcd u_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .bin    (number),
        .status (bcd)
    );

    assign ctrl     = ucode(pc_reg);
    assign num_zero = (bcd.digits == '0);

    // The billions group holds a single digit; its hundreds and tens read as zero.
    always_comb
    begin
        unique case (ctrl.grp)
            GRP_BILLIONS:
            begin
                dh = '0;
                dt = '0;
                dd = bcd.digits[9];
            end
            GRP_MILLIONS:
            begin
                dh = bcd.digits[8];
                dt = bcd.digits[7];
                dd = bcd.digits[6];
            end
            GRP_THOUSANDS:
            begin
                dh = bcd.digits[5];
                dt = bcd.digits[4];
                dd = bcd.digits[3];
            end
            default:
            begin
                dh = bcd.digits[2];
                dt = bcd.digits[1];
                dd = bcd.digits[0];
            end
        endcase
    end

    always_comb
    begin
        emit = 1'b0;
        code = CODE_ZERO;
        unique case (ctrl.op)
            OP_ZERO:
            begin
                emit = num_zero;
                code = CODE_ZERO;
            end
            OP_HUND:
            begin
                emit = (dh != '0);
                code = {1'b0, dh};
            end
            OP_HWORD:
            begin
                emit = (dh != '0);
                code = CODE_HUNDRED;
            end
            OP_TENS:
            begin
                if (dt >= 4'd2)
                begin
                    emit = 1'b1;
                    code = CODE_TENS_BASE + {1'b0, dt};
                end
                else if (dt == 4'd1)
                begin
                    emit = 1'b1;
                    code = CODE_TEN + {1'b0, dd};
                end
            end
            OP_ONES:
            begin
                emit = (dt != 4'd1) && (dd != '0);
                code = {1'b0, dd};
            end
            OP_SCALE:
            begin
                emit = ((dh | dt | dd) != '0) && (ctrl.grp != GRP_UNITS);
                code = CODE_BILLION - {3'b000, ctrl.grp};
            end
            default:
            begin
                emit = 1'b0;
                code = CODE_ZERO;
            end
        endcase
    end

    // One word is held back so that the final word of a run can be marked.
    assign out_free  = !out_valid_reg || out_ready;
    assign push_pend = (emit && pend_valid_reg) || (ctrl.op == OP_FLUSH);
    assign advance   = busy_reg && !(push_pend && !out_free)
                       && !(ctrl.op == OP_WAIT && !bcd.done);

    always_comb
    begin
        busy_next       = busy_reg;
        pc_next         = pc_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (advance)
        begin
            if (ctrl.op == OP_FLUSH)
            begin
                busy_next       = 1'b0;
                pend_valid_next = 1'b0;
            end
            else if (emit)
            begin
                pend_valid_next = 1'b1;
                pend_code_next  = code;
            end
            if (ctrl.op == OP_ZERO && num_zero)
                pc_next = ctrl.target;
            else
                pc_next = pc_reg + PC_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        if (advance && push_pend)
        begin
            out_valid_next = 1'b1;
            out_code_next  = pend_code_reg;
            out_last_next  = (ctrl.op == OP_FLUSH);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pc_reg         <= pc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign word_code = out_code_reg;
    assign last_word = out_last_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !pend_valid_reg)
        else $error("held word left over while idle");

    a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= PC_FLUSH))
        else $error("step counter ran past the program");

    a_start_program: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && pc_reg == '0))
        else $error("program did not start at step zero");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ctrl.op == OP_FLUSH) |=> (out_valid_reg && out_last_reg && !busy_reg))
        else $error("final word not marked at end of run");

endmodule
